// File: rtl/crc_stuffed_frame_encoder_top_assert.svh
// assertion macros shared by the queue and back modules
`ifndef CRC_STUFFED_FRAME_ENCODER_TOP_ASSERT_SVH
`define CRC_STUFFED_FRAME_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CRCSFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define CRCSFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/crcsfe_pkg.sv
package crcsfe_pkg;

	localparam logic [15:0] SEED_RESET = 16'd58005;
	localparam logic [7:0]  ESC_BYTE   = 8'd253;
	localparam logic [7:0]  START_BYTE = 8'd255;
	localparam logic [7:0]  END_BYTE   = 8'd254;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// one classified request as handed from front to back
	typedef struct packed {
		logic        start;
		logic        last;
		logic [7:0]  data;
		logic [15:0] crc;
	} crcsfe_desc_t;

	// crc-16 ccitt 0x1021, one byte, msb first
	function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] hi;
		logic [7:0] lo;
		x  = acc[15:8] ^ b;
		x  = x ^ {4'b0000, x[7:4]};
		hi = acc[7:0] ^ {x[3:0], 4'b0000} ^ {3'b000, x[7:3]};
		lo = x ^ {x[2:0], 5'b00000};
		return {hi, lo};
	endfunction

endpackage

// File: rtl/crc_stuffed_frame_encoder_top.sv
// byte-stuffed frame encoder with crc-16 ccitt (0x1021, msb first). each request is one
// payload byte plus packet_last. the first byte of a packet is preceded by start byte 255 and
// the crc restarts from crc_seed (reset 58005); any byte of 253 or more goes out as 253
// then byte minus 253; after the last byte come the crc low byte, the crc high byte (both
// escaped) and end byte 254. run_last marks the final line byte of each request and
// frame_end marks the 254. the front takes one request per cycle while full is low and
// computes the crc in that cycle; the back sends one line byte per cycle while its output
// register is free or being popped. a request yields 1 to 8 line bytes (typically 1 or 2),
// and a back that had gone idle first loads the request. a request reaches the result
// side through a queue entry, the back's descriptor register and the output register. a
// 4-entry queue sits between the two and an output register feeds the result side, so
// bursts are absorbed and both sides stall independently. crc_seed may be rewritten only
// while the block is idle; it is picked up at the next packet start.
module crc_stuffed_frame_encoder_top
	import crcsfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        push,
	output logic        full,
	input  logic [7:0]  payload_byte,
	input  logic        packet_last,
	// result side
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  line_byte,
	output logic        run_last,
	output logic        frame_end,
	// crc seed register
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic [15:0]  crc_seed_q;
	logic         accept;
	crcsfe_desc_t front_desc;
	crcsfe_desc_t head_desc;
	logic         fifo_empty;
	logic         head_take;

	// seed register, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_seed_q <= SEED_RESET;
		end else if (cfg_we) begin
			crc_seed_q <= cfg_wdata;
		end
	end

	// request taken whenever the queue has room
	assign accept = push & ~full;

	// front: crc update and frame tracking, one request per cycle while the queue is not full
	crcsfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.payload_byte (payload_byte),
		.packet_last  (packet_last),
		.crc_seed     (crc_seed_q),
		.desc         (front_desc)
	);

	// decoupling queue between classification and byte emission
	crcsfe_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept),
		.wr_data (front_desc),
		.rd      (head_take),
		.rd_data (head_desc),
		.full    (full),
		.empty   (fifo_empty)
	);

	// back: sequences start, escaped data, crc and end bytes
	crcsfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_desc),
		.head_valid (~fifo_empty),
		.head_take  (head_take),
		.pop        (pop),
		.empty      (empty),
		.line_byte  (line_byte),
		.run_last   (run_last),
		.frame_end  (frame_end)
	);

endmodule

// File: rtl/crcsfe_front.sv
module crcsfe_front
	import crcsfe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  logic [7:0]   payload_byte,
	input  logic         packet_last,
	input  logic [15:0]  crc_seed,
	output crcsfe_desc_t desc
);

	logic [15:0] crc_q;
	logic        inside_q;
	logic [15:0] acc;
	logic [15:0] crc_new;

	// a new frame starts from the seed
	assign acc     = inside_q ? crc_q : crc_seed;
	assign crc_new = crc_next(acc, payload_byte);

	assign desc.start = ~inside_q;
	assign desc.last  = packet_last;
	assign desc.data  = payload_byte;
	assign desc.crc   = crc_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= SEED_RESET;
			inside_q <= 1'b0;
		end else if (accept) begin
			if (packet_last) begin
				crc_q    <= crc_seed;
				inside_q <= 1'b0;
			end else begin
				crc_q    <= crc_new;
				inside_q <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/crcsfe_fifo.sv
`include "crc_stuffed_frame_encoder_top_assert.svh"

module crcsfe_fifo
	import crcsfe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  crcsfe_desc_t wr_data,
	input  logic         rd,
	output crcsfe_desc_t rd_data,
	output logic         full,
	output logic         empty
);

	crcsfe_desc_t           mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   do_wr;
	logic                   do_rd;

	assign full    = (count_q == CNT_W'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr & ~full;
	assign do_rd   = rd & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`CRCSFE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(FIFO_DEPTH), "queue count overflow")
	`CRCSFE_ASSERT_NOW(a_ptr_track, 1'b1, (count_q == '0) || (count_q == CNT_W'(FIFO_DEPTH)) || (wr_ptr_q != rd_ptr_q), "queue pointers disagree with count")
	`CRCSFE_ASSERT_NOW(a_full_empty, 1'b1, !(full && empty), "queue full and empty at once")

endmodule

// File: rtl/crcsfe_back.sv
`include "crc_stuffed_frame_encoder_top_assert.svh"

module crcsfe_back
	import crcsfe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  crcsfe_desc_t head,
	input  logic         head_valid,
	output logic         head_take,
	input  logic         pop,
	output logic         empty,
	output logic [7:0]   line_byte,
	output logic         run_last,
	output logic         frame_end
);

	typedef enum logic [4:0] {
		PH_START = 5'b00001,
		PH_DATA  = 5'b00010,
		PH_LO    = 5'b00100,
		PH_HI    = 5'b01000,
		PH_END   = 5'b10000
	} phase_t;

	crcsfe_desc_t desc_q;
	logic         busy_q;
	phase_t       phase_q;
	phase_t       nxt_phase;
	logic         esc2_q;
	logic         out_valid_q;
	logic [7:0]   line_byte_q;
	logic         run_last_q;
	logic         frame_end_q;

	logic [7:0]   v;
	logic         escapable;
	logic         need_esc;
	logic [7:0]   emit;
	logic         done;
	logic         advance;
	logic         load;

	always_comb begin
		v         = desc_q.data;
		nxt_phase = PH_END;
		case (phase_q)
			PH_START: begin
				v         = START_BYTE;
				nxt_phase = PH_DATA;
			end
			PH_DATA: begin
				v         = desc_q.data;
				nxt_phase = PH_LO;
			end
			PH_LO: begin
				v         = desc_q.crc[7:0];
				nxt_phase = PH_HI;
			end
			PH_HI: begin
				v         = desc_q.crc[15:8];
				nxt_phase = PH_END;
			end
			PH_END: begin
				v         = END_BYTE;
				nxt_phase = PH_END;
			end
			default: begin
				v         = desc_q.data;
				nxt_phase = PH_END;
			end
		endcase
	end

	assign escapable = (phase_q != PH_START) && (phase_q != PH_END);
	assign need_esc  = escapable && !esc2_q && (v >= ESC_BYTE);
	assign emit      = esc2_q ? (v - ESC_BYTE) : (need_esc ? ESC_BYTE : v);
	assign done      = !need_esc && ((phase_q == PH_END) || ((phase_q == PH_DATA) && !desc_q.last));

	// busy and output slot free or being drained
	assign advance   = busy_q && (!out_valid_q || pop);
	assign load      = head_valid && (!busy_q || (advance && done));
	assign head_take = load;

	assign empty     = ~out_valid_q;
	assign line_byte = line_byte_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= head;
		end
		if (advance) begin
			line_byte_q <= emit;
			run_last_q  <= done;
			frame_end_q <= (phase_q == PH_END);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_START;
			esc2_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				busy_q  <= 1'b1;
				phase_q <= head.start ? PH_START : PH_DATA;
				esc2_q  <= 1'b0;
			end else if (advance) begin
				if (done) begin
					busy_q <= 1'b0;
				end
				esc2_q <= need_esc;
				if (!need_esc) begin
					phase_q <= nxt_phase;
				end
			end
		end
	end

	`CRCSFE_ASSERT_NOW(a_end_byte, out_valid_q && frame_end_q, (line_byte_q == END_BYTE) && run_last_q, "end marker without end byte or run_last")
	`CRCSFE_ASSERT_NOW(a_esc_phase, esc2_q, (phase_q == PH_DATA) || (phase_q == PH_LO) || (phase_q == PH_HI), "escape pending outside an escapable byte")
	`CRCSFE_ASSERT_NEXT(a_esc_follow, advance && need_esc, out_valid_q && (line_byte_q == ESC_BYTE) && !run_last_q, "escape byte not emitted")

endmodule
